// File: sv/sfla_pkg.sv
package sfla_pkg;

   localparam int ADDR_BITS_DEFAULT         = 26;
   localparam int SMALL_BLOCK_BYTES_DEFAULT = 16384;

   localparam int UNIT_SHIFT       = 6;
   localparam int NUM_CLASSES      = 5;
   localparam int TOP_CHUNK_BYTES  = 4 * 4096;
   localparam int TOP_CHUNK_SHIFT  = 14;
   localparam int REG_WIDTH        = 27;
   localparam int SIZE_WIDTH       = 32;
   localparam int ADDR_FIELD_WIDTH = 26;
   localparam int COUNT_WIDTH      = 32;
   localparam int CLASS_WIDTH      = 3;
   localparam int UNITS_WIDTH      = 9;

   localparam logic [CLASS_WIDTH-1:0] LARGE_CLASS = CLASS_WIDTH'(NUM_CLASSES - 1);

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_NO_MEMORY = 2'd2,
      ST_NOT_INIT  = 2'd3
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic {
      CSR_REGION_SIZE  = 1'b0,
      CSR_LARGE_EXPAND = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      CS_IDLE,
      CS_CLASSIFY,
      CS_TGT_POP,
      CS_LRG_CHECK,
      CS_LRG_POP,
      CS_LRG_EXP,
      CS_LRG_CARVE,
      CS_SML_EXP,
      CS_TGT_CARVE,
      CS_RESPOND
   } ctl_state_type;

   typedef struct packed {
      logic       load;
      logic       set_init;
      logic       sel_large;
      logic       mem_rd;
      logic       pop;
      logic       carve;
      logic       grow_large;
      logic       grow_small;
      logic       push;
      logic       set_status;
      status_type status;
      logic       respond;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic init;
      logic ptr_valid;
      logic class_ok;
      logic tgt_large;
      logic top_valid;
      logic carve_ok;
      logic lrg_top_valid;
      logic lrg_carve_ok;
      logic large_fits;
      logic rsp_free;
   } dp_stat_type;

   // Smallest class whose block size holds the request; ok is clear when none does.
   function automatic logic [CLASS_WIDTH:0] class_of(input logic [SIZE_WIDTH-1:0] size);
      logic [CLASS_WIDTH:0] res;
      begin
         if (size <= SIZE_WIDTH'(64)) begin
            res = {1'b1, CLASS_WIDTH'(0)};
         end else if (size <= SIZE_WIDTH'(256)) begin
            res = {1'b1, CLASS_WIDTH'(1)};
         end else if (size <= SIZE_WIDTH'(1024)) begin
            res = {1'b1, CLASS_WIDTH'(2)};
         end else if (size <= SIZE_WIDTH'(4096)) begin
            res = {1'b1, CLASS_WIDTH'(3)};
         end else if (size <= SIZE_WIDTH'(TOP_CHUNK_BYTES)) begin
            res = {1'b1, LARGE_CLASS};
         end else begin
            res = {1'b0, LARGE_CLASS};
         end
         return res;
      end
   endfunction

   // Block size of a class in 64-byte units.
   function automatic logic [UNITS_WIDTH-1:0] class_units(input logic [CLASS_WIDTH-1:0] c);
      logic [UNITS_WIDTH-1:0] res;
      begin
         unique case (c)
            3'd0:    res = UNITS_WIDTH'(1);
            3'd1:    res = UNITS_WIDTH'(4);
            3'd2:    res = UNITS_WIDTH'(16);
            3'd3:    res = UNITS_WIDTH'(64);
            default: res = UNITS_WIDTH'(256);
         endcase
         return res;
      end
   endfunction

endpackage

// File: sv/segregated_free_list_allocator_unit.sv
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: size, address; tuser: req_type, pointer_valid
// rsp      out        rsp_tvalid/rsp_tready  tdata: chunk_address, expansion_total; tuser: status
// csr      in         csr_valid/csr_ready    csr_index, csr_data (always ready)
//
// One item at a time: a free, an oversize request or an alloc served by a carve is
// the quickest, a free-list pop waits on a registered link-memory read, and an empty
// class may have to take a top-class chunk and grow the bump pointer.
// The result sits in an output register, so the next item is taken while it waits.
// Reset is synchronous; the link memory is not cleared, as every entry is written
// by a free before a pop reads it.
module segregated_free_list_allocator_unit #(
   parameter int ADDR_BITS         = sfla_pkg::ADDR_BITS_DEFAULT,
   parameter int SMALL_BLOCK_BYTES = sfla_pkg::SMALL_BLOCK_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [63:0]                    req_tdata,  // size[31:0], address[57:32]
   input  logic [1:0]                     req_tuser,  // req_type[0], pointer_valid[1]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [63:0]                    rsp_tdata,  // chunk_address[25:0], expansion_total[57:26]
   output logic [1:0]                     rsp_tuser,  // status[1:0]
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  sfla_pkg::csr_index_type        csr_index,
   input  logic [sfla_pkg::REG_WIDTH-1:0] csr_data
);

   import sfla_pkg::*;

   dp_cmd_type                  cmd;
   dp_stat_type                 stat;
   logic [ADDR_FIELD_WIDTH-1:0] chunk_address;
   status_type                  status;
   logic [COUNT_WIDTH-1:0]      expansion_total;

   assign csr_ready = 1'b1;

   sfla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   sfla_datapath #(
      .ADDR_BITS         (ADDR_BITS),
      .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_tuser[0]),
      .size            (req_tdata[SIZE_WIDTH-1:0]),
      .address         (req_tdata[SIZE_WIDTH +: ADDR_FIELD_WIDTH]),
      .pointer_valid   (req_tuser[1]),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .chunk_address   (chunk_address),
      .status          (status),
      .expansion_total (expansion_total)
   );

   assign rsp_tdata = {{(64 - ADDR_FIELD_WIDTH - COUNT_WIDTH){1'b0}},
                       expansion_total, chunk_address};
   assign rsp_tuser = status;

endmodule

// File: sv/sfla_ram.sv
module sfla_ram #(
   parameter int WIDTH      = 21,
   parameter int DEPTH_LOG2 = 20
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [DEPTH_LOG2-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [DEPTH_LOG2-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [2**DEPTH_LOG2];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/sfla_ctrl.sv
module sfla_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  sfla_pkg::dp_stat_type stat,
   output sfla_pkg::dp_cmd_type  cmd
);

   import sfla_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_tvalid) begin
               state_in = CS_CLASSIFY;
            end
         end
         CS_CLASSIFY: begin
            priority if (stat.is_free || !stat.class_ok) begin
               state_in = CS_RESPOND;
            end else if (stat.top_valid) begin
               state_in = CS_TGT_POP;
            end else if (stat.carve_ok) begin
               state_in = CS_RESPOND;
            end else if (stat.tgt_large) begin
               state_in = CS_LRG_EXP;
            end else begin
               state_in = CS_LRG_CHECK;
            end
         end
         CS_TGT_POP: state_in = CS_RESPOND;
         CS_LRG_CHECK: begin
            priority if (stat.lrg_top_valid) begin
               state_in = CS_LRG_POP;
            end else if (stat.lrg_carve_ok) begin
               state_in = CS_SML_EXP;
            end else begin
               state_in = CS_LRG_EXP;
            end
         end
         CS_LRG_POP: state_in = CS_SML_EXP;
         CS_LRG_EXP: begin
            priority if (!stat.large_fits) begin
               state_in = CS_RESPOND;
            end else if (stat.tgt_large) begin
               state_in = CS_TGT_CARVE;
            end else begin
               state_in = CS_LRG_CARVE;
            end
         end
         CS_LRG_CARVE: state_in = CS_SML_EXP;
         CS_SML_EXP:   state_in = CS_TGT_CARVE;
         CS_TGT_CARVE: state_in = CS_RESPOND;
         CS_RESPOND: begin
            if (stat.rsp_free) begin
               state_in = CS_IDLE;
            end
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      cmd.status = ST_OK;
      req_tready = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         CS_CLASSIFY: begin
            cmd.set_status = 1'b1;
            if (stat.is_free) begin
               priority if (!stat.init) begin
                  cmd.status = ST_NOT_INIT;
               end else if (!stat.ptr_valid) begin
                  cmd.status = ST_OK;
               end else if (!stat.class_ok) begin
                  cmd.status = ST_TOO_LARGE;
               end else begin
                  cmd.status = ST_OK;
                  cmd.push   = 1'b1;
               end
            end else begin
               cmd.set_init = 1'b1;
               priority if (!stat.class_ok) begin
                  cmd.status = ST_TOO_LARGE;
               end else if (stat.top_valid) begin
                  cmd.mem_rd = 1'b1;
               end else if (stat.carve_ok) begin
                  cmd.carve = 1'b1;
               end else begin
                  cmd.status = ST_OK;
               end
            end
         end
         CS_TGT_POP: cmd.pop = 1'b1;
         CS_LRG_CHECK: begin
            cmd.sel_large = 1'b1;
            priority if (stat.lrg_top_valid) begin
               cmd.mem_rd = 1'b1;
            end else if (stat.lrg_carve_ok) begin
               cmd.carve = 1'b1;
            end else begin
               cmd.carve = 1'b0;
            end
         end
         CS_LRG_POP: begin
            cmd.sel_large = 1'b1;
            cmd.pop       = 1'b1;
         end
         CS_LRG_EXP: begin
            if (stat.large_fits) begin
               cmd.grow_large = 1'b1;
            end else begin
               cmd.set_status = 1'b1;
               cmd.status     = ST_NO_MEMORY;
            end
         end
         CS_LRG_CARVE: begin
            cmd.sel_large = 1'b1;
            cmd.carve     = 1'b1;
         end
         CS_SML_EXP:   cmd.grow_small = 1'b1;
         CS_TGT_CARVE: cmd.carve      = 1'b1;
         CS_RESPOND:   cmd.respond    = stat.rsp_free;
         default:      cmd.load       = 1'b0;
      endcase
   end

endmodule

// File: sv/sfla_datapath.sv
module sfla_datapath #(
   parameter int ADDR_BITS         = sfla_pkg::ADDR_BITS_DEFAULT,
   parameter int SMALL_BLOCK_BYTES = sfla_pkg::SMALL_BLOCK_BYTES_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_type,
   input  logic [sfla_pkg::SIZE_WIDTH-1:0]       size,
   input  logic [sfla_pkg::ADDR_FIELD_WIDTH-1:0] address,
   input  logic                                  pointer_valid,
   input  logic                                  csr_write,
   input  sfla_pkg::csr_index_type               csr_index,
   input  logic [sfla_pkg::REG_WIDTH-1:0]        csr_data,
   input  sfla_pkg::dp_cmd_type                  cmd,
   output sfla_pkg::dp_stat_type                 stat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [sfla_pkg::ADDR_FIELD_WIDTH-1:0] chunk_address,
   output sfla_pkg::status_type                  status,
   output logic [sfla_pkg::COUNT_WIDTH-1:0]      expansion_total
);

   import sfla_pkg::*;

   localparam int IDX = ADDR_BITS - UNIT_SHIFT;
   localparam int CW  = IDX + 1;
   localparam int BW  = (ADDR_BITS + 1 > REG_WIDTH) ? ADDR_BITS + 1 : REG_WIDTH;
   localparam int AW  = (ADDR_BITS > ADDR_FIELD_WIDTH) ? ADDR_BITS : ADDR_FIELD_WIDTH;
   localparam int SB_BYTES =
      (SMALL_BLOCK_BYTES < TOP_CHUNK_BYTES) ? SMALL_BLOCK_BYTES : TOP_CHUNK_BYTES;
   localparam int SB_UNITS = SB_BYTES >> UNIT_SHIFT;

   // Configuration.
   logic [REG_WIDTH-1:0] region_ff, region_in;
   logic [REG_WIDTH-1:0] expand_ff, expand_in;

   // Request held for the duration of one item.
   logic                         kind_ff;
   logic                         ptr_ff;
   logic [CLASS_WIDTH-1:0]       cls_ff;
   logic                         cls_ok_ff;
   logic [ADDR_FIELD_WIDTH-1:0]  addr_ff;

   // Allocator state.
   logic                   init_ff, init_in;
   logic [NUM_CLASSES-1:0] top_valid_ff, top_valid_in;
   logic [IDX-1:0]         top_ff [NUM_CLASSES];
   logic [IDX-1:0]         top_in [NUM_CLASSES];
   logic [CW-1:0]          cnext_ff [NUM_CLASSES];
   logic [CW-1:0]          cnext_in [NUM_CLASSES];
   logic [CW-1:0]          cend_ff [NUM_CLASSES];
   logic [CW-1:0]          cend_in [NUM_CLASSES];
   logic [BW-1:0]          bump_ff, bump_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [IDX-1:0]         unit_ff, unit_in;
   status_type             status_ff, status_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ADDR_FIELD_WIDTH-1:0] rsp_chunk_ff;
   status_type                  rsp_status_ff;
   logic [COUNT_WIDTH-1:0]      rsp_count_ff;

   logic [CLASS_WIDTH:0]   class_code;
   logic [CLASS_WIDTH-1:0] sel;
   logic [CW-1:0]          step;
   logic [CW:0]            carve_sum;
   logic [CW:0]            tgt_carve_sum;
   logic [CW:0]            lrg_carve_sum;
   logic [REG_WIDTH-1:0]   amt_raw;
   logic [REG_WIDTH-1:0]   amt;
   logic [BW-1:0]          region_ext;
   logic [BW-1:0]          addr_span;
   logic [BW-1:0]          limit;
   logic [BW:0]            bump_sum;
   logic                   fits;
   logic [AW-1:0]          free_addr_ext;
   logic [IDX-1:0]         free_unit;
   logic [IDX:0]           link_wr;
   logic [IDX:0]           link_rd;
   logic [AW-1:0]          chunk_ext;

   assign class_code = class_of(size);
   assign sel        = cmd.sel_large ? LARGE_CLASS : cls_ff;
   assign step       = CW'(class_units(sel));
   assign carve_sum  = {1'b0, cnext_ff[sel]} + {1'b0, step};

   // The status to the controller looks at the target and the top class on fixed
   // selects, so that it never depends on the commands it steers.
   assign tgt_carve_sum = {1'b0, cnext_ff[cls_ff]} + {1'b0, CW'(class_units(cls_ff))};
   assign lrg_carve_sum = {1'b0, cnext_ff[LARGE_CLASS]} +
                          {1'b0, CW'(class_units(LARGE_CLASS))};

   // A rounded expansion of zero is taken as one top-class chunk.
   assign amt_raw    = {expand_ff[REG_WIDTH-1:TOP_CHUNK_SHIFT], TOP_CHUNK_SHIFT'(0)};
   assign amt        = (amt_raw == '0) ? REG_WIDTH'(TOP_CHUNK_BYTES) : amt_raw;
   assign region_ext = BW'(region_ff);
   assign addr_span  = BW'(1) << ADDR_BITS;
   assign limit      = (region_ext < addr_span) ? region_ext : addr_span;
   assign bump_sum   = {1'b0, bump_ff} + (BW + 1)'(amt);
   assign fits       = bump_sum <= {1'b0, limit};

   assign free_addr_ext = AW'(addr_ff);
   assign free_unit     = free_addr_ext[UNIT_SHIFT +: IDX];
   assign link_wr       = top_valid_ff[sel] ? {1'b1, top_ff[sel]} : '0;
   assign chunk_ext     = AW'({unit_ff, {UNIT_SHIFT{1'b0}}});

   sfla_ram #(
      .WIDTH      (IDX + 1),
      .DEPTH_LOG2 (IDX)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (free_unit),
      .wr_data (link_wr),
      .rd_en   (cmd.mem_rd),
      .rd_addr (top_ff[sel]),
      .rd_data (link_rd)
   );

   always_comb begin
      region_in    = region_ff;
      expand_in    = expand_ff;
      init_in      = init_ff;
      top_valid_in = top_valid_ff;
      top_in       = top_ff;
      cnext_in     = cnext_ff;
      cend_in      = cend_ff;
      bump_in      = bump_ff;
      count_in     = count_ff;
      unit_in      = unit_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_REGION_SIZE:  region_in = csr_data;
            CSR_LARGE_EXPAND: expand_in = csr_data;
            default:          region_in = region_ff;
         endcase
      end
      if (cmd.set_init) begin
         init_in = 1'b1;
      end
      if (cmd.set_status) begin
         status_in = cmd.status;
      end
      if (cmd.pop) begin
         top_valid_in[sel] = link_rd[IDX];
         top_in[sel]       = link_rd[IDX-1:0];
         unit_in           = top_ff[sel];
      end
      if (cmd.carve) begin
         unit_in       = cnext_ff[sel][IDX-1:0];
         cnext_in[sel] = carve_sum[CW-1:0];
      end
      if (cmd.push) begin
         top_in[sel]       = free_unit;
         top_valid_in[sel] = 1'b1;
      end
      if (cmd.grow_large) begin
         cnext_in[LARGE_CLASS] = bump_ff[UNIT_SHIFT +: CW];
         cend_in[LARGE_CLASS]  = bump_sum[UNIT_SHIFT +: CW];
         bump_in               = bump_sum[BW-1:0];
      end
      // The chunk just taken from the top class becomes the target's carve region.
      if (cmd.grow_small) begin
         cnext_in[cls_ff] = {1'b0, unit_ff};
         cend_in[cls_ff]  = {1'b0, unit_ff} + CW'(SB_UNITS);
      end
      if ((cmd.grow_large || cmd.grow_small) && (count_ff != '1)) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= REG_WIDTH'(67108864);
         expand_ff    <= REG_WIDTH'(1024 * 1024 * 16);
         init_ff      <= 1'b0;
         top_valid_ff <= '0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            cnext_ff[i] <= '0;
            cend_ff[i]  <= '0;
         end
         bump_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         region_ff    <= region_in;
         expand_ff    <= expand_in;
         init_ff      <= init_in;
         top_valid_ff <= top_valid_in;
         cnext_ff     <= cnext_in;
         cend_ff      <= cend_in;
         bump_ff      <= bump_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff    <= top_in;
      unit_ff   <= unit_in;
      status_ff <= status_in;
      if (cmd.load) begin
         kind_ff   <= req_type;
         ptr_ff    <= pointer_valid;
         cls_ff    <= class_code[CLASS_WIDTH-1:0];
         cls_ok_ff <= class_code[CLASS_WIDTH];
         addr_ff   <= address;
      end
      if (cmd.respond) begin
         rsp_chunk_ff  <= ((kind_ff == REQ_ALLOC) && (status_ff == ST_OK)) ?
                          chunk_ext[ADDR_FIELD_WIDTH-1:0] : '0;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   always_comb begin
      stat.is_free       = (kind_ff == REQ_FREE);
      stat.init          = init_ff;
      stat.ptr_valid     = ptr_ff;
      stat.class_ok      = cls_ok_ff;
      stat.tgt_large     = (cls_ff == LARGE_CLASS);
      stat.top_valid     = top_valid_ff[cls_ff];
      stat.carve_ok      = tgt_carve_sum <= {1'b0, cend_ff[cls_ff]};
      stat.lrg_top_valid = top_valid_ff[LARGE_CLASS];
      stat.lrg_carve_ok  = lrg_carve_sum <= {1'b0, cend_ff[LARGE_CLASS]};
      stat.large_fits    = fits;
      stat.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign chunk_address   = rsp_chunk_ff;
   assign status          = rsp_status_ff;
   assign expansion_total = rsp_count_ff;

endmodule

// File: bench/tb_segregated_free_list_allocator_unit.sv
typedef struct {
   sfla_pkg::req_kind_type kind;
   logic [31:0]            size;
   logic [25:0]            address;
   logic                   ptr_valid;
} alloc_req_t;

typedef struct {
   logic [25:0]          chunk;
   sfla_pkg::status_type status;
   logic [31:0]          expansions;
} alloc_rsp_t;

typedef struct {
   logic [25:0] address;
   int          cls;
} live_block_t;

class alloc_scoreboard;
   int unsigned     errors;
   int unsigned     checked;
   alloc_rsp_t      awaited[$];

   // Mirror of the allocator; block positions are kept in 64-byte units.
   bit              init_done;
   bit              top_valid [5];
   int unsigned     top_unit [5];
   longint unsigned carve_next [5];
   longint unsigned carve_end [5];
   longint unsigned bump;
   logic [31:0]     expansions;
   bit [20:0]       link_mem [int unsigned];
   longint unsigned region_bytes;
   longint unsigned expand_bytes;

   function new();
      region_bytes = 64'd67108864;
      expand_bytes = 64'd16777216;
      expansions   = '0;
   endfunction

   function void set_reg(sfla_pkg::csr_index_type idx, logic [sfla_pkg::REG_WIDTH-1:0] val);
      if (idx == sfla_pkg::CSR_REGION_SIZE) region_bytes = val;
      else expand_bytes = val;
   endfunction

   function int size_class(logic [31:0] size);
      for (int c = 0; c < 5; c++) begin
         if (size <= (64'd64 << (2 * c))) return c;
      end
      return -1;
   endfunction

   function int pending();
      return awaited.size();
   endfunction

   function void count_expansion();
      if (expansions != 32'hFFFF_FFFF) expansions++;
   endfunction

   function bit pop_or_carve(int c, output longint unsigned unit);
      longint unsigned stride = 64'd1 << (2 * c);
      bit [20:0]       lnk;
      if (top_valid[c]) begin
         unit = top_unit[c];
         lnk = link_mem.exists(top_unit[c]) ? link_mem[top_unit[c]] : '0;
         top_valid[c] = lnk[20];
         top_unit[c] = lnk[19:0];
         return 1'b1;
      end
      if (carve_next[c] + stride <= carve_end[c]) begin
         unit = carve_next[c];
         carve_next[c] += stride;
         return 1'b1;
      end
      unit = 0;
      return 1'b0;
   endfunction

   function bit grow_top();
      longint unsigned amount = (expand_bytes / sfla_pkg::TOP_CHUNK_BYTES)
                                * sfla_pkg::TOP_CHUNK_BYTES;
      longint unsigned ceiling = (region_bytes < (64'd1 << 26)) ? region_bytes : (64'd1 << 26);
      if (amount == 0) amount = sfla_pkg::TOP_CHUNK_BYTES;
      if (bump + amount > ceiling) return 1'b0;
      carve_next[4] = bump >> sfla_pkg::UNIT_SHIFT;
      carve_end[4] = (bump + amount) >> sfla_pkg::UNIT_SHIFT;
      bump += amount;
      count_expansion();
      return 1'b1;
   endfunction

   function bit take_top(output longint unsigned unit);
      if (pop_or_carve(4, unit)) return 1'b1;
      if (!grow_top()) return 1'b0;
      return pop_or_carve(4, unit);
   endfunction

   function bit take_block(int c, output longint unsigned unit);
      longint unsigned base;
      longint unsigned span;
      span = (sfla_pkg::SMALL_BLOCK_BYTES_DEFAULT < sfla_pkg::TOP_CHUNK_BYTES) ?
             sfla_pkg::SMALL_BLOCK_BYTES_DEFAULT : sfla_pkg::TOP_CHUNK_BYTES;
      unit = 0;
      if (c == 4) return take_top(unit);
      if (pop_or_carve(c, unit)) return 1'b1;
      // A small class that has run dry carves a fresh chunk taken from the top class.
      if (!take_top(base)) return 1'b0;
      carve_next[c] = base;
      carve_end[c] = base + (span >> sfla_pkg::UNIT_SHIFT);
      count_expansion();
      return pop_or_carve(c, unit);
   endfunction

   function alloc_rsp_t note(alloc_req_t r);
      alloc_rsp_t      res;
      longint unsigned unit;
      int unsigned     u;
      int              c;
      res.chunk = '0;
      res.status = sfla_pkg::ST_OK;
      c = size_class(r.size);
      if (r.kind == sfla_pkg::REQ_ALLOC) begin
         init_done = 1'b1;
         if (c < 0) res.status = sfla_pkg::ST_TOO_LARGE;
         else if (take_block(c, unit)) res.chunk = 26'(unit << sfla_pkg::UNIT_SHIFT);
         else res.status = sfla_pkg::ST_NO_MEMORY;
      end else if (!init_done) begin
         res.status = sfla_pkg::ST_NOT_INIT;
      end else if (r.ptr_valid) begin
         if (c < 0) begin
            res.status = sfla_pkg::ST_TOO_LARGE;
         end else begin
            u = r.address >> sfla_pkg::UNIT_SHIFT;
            link_mem[u] = top_valid[c] ? {1'b1, 20'(top_unit[c])} : 21'd0;
            top_unit[c] = u;
            top_valid[c] = 1'b1;
         end
      end
      res.expansions = expansions;
      awaited.push_back(res);
      return res;
   endfunction

   task report(string what);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task check(alloc_rsp_t got);
      alloc_rsp_t want;
      checked++;
      if (awaited.size() == 0) begin
         report($sformatf("result with nothing awaited: chunk %h status %0d", got.chunk,
                          got.status));
         return;
      end
      want = awaited.pop_front();
      if (got.chunk !== want.chunk)
         report($sformatf("chunk_address %h, expected %h", got.chunk, want.chunk));
      if (got.status !== want.status)
         report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.expansions !== want.expansions)
         report($sformatf("expansion_total %0d, expected %0d", got.expansions,
                          want.expansions));
   endtask
endclass

module tb_segregated_free_list_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import sfla_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 400;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [63:0]          req_tdata;
   logic [1:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [63:0]          rsp_tdata;
   logic [1:0]           rsp_tuser;
   logic                 csr_valid;
   logic                 csr_ready;
   csr_index_type        csr_index;
   logic [REG_WIDTH-1:0] csr_data;

   alloc_scoreboard sb;
   live_block_t     live_q[$];
   int              burst_left;

   segregated_free_list_allocator_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic alloc_req_t mk(req_kind_type kind, logic [31:0] size,
                                     logic [25:0] address, logic ptr_valid);
      alloc_req_t it;
      it.kind = kind;
      it.size = size;
      it.address = address;
      it.ptr_valid = ptr_valid;
      return it;
   endfunction

   function automatic logic [31:0] size_in_class(int c);
      int unsigned lo = (c == 0) ? 0 : (64 << (2 * (c - 1))) + 1;
      int unsigned hi = 64 << (2 * c);
      return $urandom_range(hi, lo);
   endfunction

   task automatic pace();
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(12, 1)) @(negedge clock);
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(150, 40) :
                      $urandom_range(6, 1);
      end
      burst_left--;
   endtask

   task automatic drive_item(alloc_req_t it);
      alloc_rsp_t pred;
      pace();
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, it.address, it.size};
      req_tuser <= {it.ptr_valid, it.kind};
      do @(posedge clock); while (req_tready !== 1'b1);
      pred = sb.note(it);
      if (it.kind == REQ_ALLOC && pred.status == ST_OK)
         live_q.push_back('{pred.chunk, sb.size_class(it.size)});
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic write_reg(csr_index_type idx, logic [REG_WIDTH-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [REG_WIDTH-1:0] region, logic [REG_WIDTH-1:0] expand);
      write_reg(CSR_REGION_SIZE, region);
      write_reg(CSR_LARGE_EXPAND, expand);
   endtask

   // Mostly alloc and free of live blocks with matching sizes; a little noise.
   task automatic run_random(int count);
      alloc_req_t  it;
      live_block_t blk;
      int          pick;
      int          idx;
      int          c;
      repeat (count) begin
         pick = $urandom_range(99, 0);
         c = $urandom_range(4, 0);
         if (pick < 8) begin
            case (pick % 4)
               0: it = mk(REQ_FREE, $urandom(), 26'($urandom()), 1'b0);
               1: it = mk(REQ_ALLOC, $urandom_range(32'hFFFF_FFFF, 32'd16385),
                          26'($urandom()), 1'($urandom()));
               2: it = mk(REQ_FREE, $urandom_range(32'hFFFF_FFFF, 32'd16385),
                          26'($urandom()), 1'b1);
               default: it = mk(REQ_FREE, size_in_class(c), 26'($urandom()), 1'b1);
            endcase
         end else if (live_q.size() > 0 && pick < (live_q.size() > 40 ? 65 : 45)) begin
            idx = $urandom_range(live_q.size() - 1, 0);
            blk = live_q[idx];
            live_q.delete(idx);
            if ($urandom_range(3, 0) == 0) blk.address[5:0] = 6'($urandom());
            it = mk(REQ_FREE, size_in_class(blk.cls), blk.address, 1'b1);
         end else begin
            it = mk(REQ_ALLOC, size_in_class(c), 26'($urandom()), 1'($urandom()));
         end
         drive_item(it);
      end
   endtask

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_tvalid === 1'b1 && rsp_tready === 1'b1)
         sb.check(alloc_rsp_t'{rsp_tdata[25:0], status_type'(rsp_tuser), rsp_tdata[57:26]});
   end

   initial begin : receiver
      int seg_len;
      int mode;
      bit held;
      rsp_tready = 1'b0;
      held = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         mode = $urandom_range(2, 0);
         seg_len = $urandom_range(80, 10);
         // One long hold-off so that the output register and then the input back up.
         if (!held && sb.checked >= 300) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         for (int k = 0; k < seg_len; k++) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom());
               default: rsp_tready <= ((k % 7) < 2) ? 1'b0 : 1'b1;
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_valid = 1'b0;
      csr_index = CSR_REGION_SIZE;
      csr_data = '0;
      burst_left = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // No memory at all, and an expansion size that rounds down to nothing.
      configure(27'd0, 27'd0);
      drive_item(mk(REQ_FREE, 32'd64, 26'h40, 1'b1));
      drive_item(mk(REQ_FREE, 32'd64, 26'h40, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd100, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd16385, 26'd0, 1'b1));
      drive_item(mk(REQ_ALLOC, 32'hFFFF_FFFF, 26'h3FF_FFFF, 1'b0));
      drive_item(mk(REQ_FREE, 32'hFFFF_FFFF, 26'h3FF_FFFF, 1'b0));
      drive_item(mk(REQ_FREE, 32'hFFFF_FFFF, 26'h3FF_FFFF, 1'b1));
      drive_item(mk(REQ_FREE, 32'd16384, 26'h3FF_FFFF, 1'b1));
      drive_item(mk(REQ_ALLOC, 32'd16384, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd4096, 26'd0, 1'b0));
      drain();

      // Room for four top-class chunks, one per expansion.
      configure(27'd65536, 27'd16384);
      drive_item(mk(REQ_ALLOC, 32'd0, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd64, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd65, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd256, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd1024, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd4096, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd16384, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd16384, 26'd0, 1'b0));
      drive_item(mk(REQ_ALLOC, 32'd4000, 26'd0, 1'b0));
      drive_item(mk(REQ_FREE, 32'd1, 26'd69, 1'b1));
      drive_item(mk(REQ_ALLOC, 32'd10, 26'd0, 1'b0));
      drive_item(mk(REQ_FREE, 32'd64, 26'd0, 1'b0));
      drain();
      live_q.delete();

      configure(27'h7FF_FFFF, 27'd20000);
      run_random(450);
      drain();
      configure(27'd67108864, 27'd67108864);
      run_random(300);
      drain();
      configure(27'd67108864, 27'd100000);
      run_random(400);
      drain();
      configure(27'd4194304, 27'd1048576);
      run_random(400);
      drain();
      configure(27'd0, 27'h7FF_FFFF);
      run_random(250);
      drain();

      repeat (12) @(negedge clock);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
